// File: sv/soq_pkg.sv
// ----------------------------------------------------------------------------
// seat occupancy qualifier package
// shared widths and phase codes for the qualifier and its checker
// ----------------------------------------------------------------------------
`default_nettype none

package soq_pkg;

   localparam int TIME_WIDTH    = 31;
   localparam int TIMEOUT_WIDTH = 31;
   localparam int PHASE_WIDTH   = 3;
   localparam int CMP_WIDTH     = (TIME_WIDTH > TIMEOUT_WIDTH) ? TIME_WIDTH : TIMEOUT_WIDTH;

   localparam logic [PHASE_WIDTH-1:0] PHASE_IDLE          = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PHASE_CONFIRM_SEAT  = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_STARTED       = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PHASE_SEATED        = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PHASE_CONFIRM_LEAVE = 3'd4;
   localparam logic [PHASE_WIDTH-1:0] PHASE_STOPPED       = 3'd5;

endpackage

`default_nettype wire

// File: sv/seat_occupancy_qualifier_unit.sv
// ----------------------------------------------------------------------------
// seat occupancy qualifier unit
// timed debounce of a timestamped seat-occupied flag with start/stop stamps
// ----------------------------------------------------------------------------
// usage:
//   req_ channel: one sensor sample per beat (seat_occupied, timestamp).
//   rsp_ channel: one result per sample (phase_code, start_stamp, stop_stamp),
//   in sample order. Both channels move a beat when valid is high and stall
//   is low.
//   csr_ channel: confirm_timeout write, always ready; write it only while
//   no sample is in flight.
//   pipeline: two register stages, the sample register, then the result
//   register; a stalled receiver can hold a sample between them.
//   throughput: one sample per cycle while the receiver does not stall; the
//   phase machine and the single subtract-and-compare for expiry update once per sample.
//   reset: phase goes to idle, both stamps and the timeout clear, both
//   stages empty.
//   receiver stall: the result register holds; the sample register keeps
//   taking beats until it is also full, then req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module seat_occupancy_qualifier_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic                                   req_seat_occupied,
   input  wire logic [soq_pkg::TIME_WIDTH-1:0]         req_timestamp,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [soq_pkg::PHASE_WIDTH-1:0]        rsp_phase_code,
   output      logic [soq_pkg::TIME_WIDTH-1:0]         rsp_start_stamp,
   output      logic [soq_pkg::TIME_WIDTH-1:0]         rsp_stop_stamp,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [soq_pkg::TIMEOUT_WIDTH-1:0]      csr_confirm_timeout
);

   typedef enum logic [soq_pkg::PHASE_WIDTH-1:0] {
      PH_IDLE          = soq_pkg::PHASE_IDLE,
      PH_CONFIRM_SEAT  = soq_pkg::PHASE_CONFIRM_SEAT,
      PH_STARTED       = soq_pkg::PHASE_STARTED,
      PH_SEATED        = soq_pkg::PHASE_SEATED,
      PH_CONFIRM_LEAVE = soq_pkg::PHASE_CONFIRM_LEAVE,
      PH_STOPPED       = soq_pkg::PHASE_STOPPED
   } phase_type;

   logic [soq_pkg::TIMEOUT_WIDTH-1:0] timeout_ff;

   logic                              in_valid_ff;
   logic                              in_occ_ff;
   logic [soq_pkg::TIME_WIDTH-1:0]    in_time_ff;

   phase_type                         phase_ff, phase_in;
   logic [soq_pkg::TIME_WIDTH-1:0]    started_ff, started_in;
   logic [soq_pkg::TIME_WIDTH-1:0]    stopped_ff, stopped_in;

   logic                              rsp_valid_ff;
   logic [soq_pkg::PHASE_WIDTH-1:0]   rsp_phase_ff;
   logic [soq_pkg::TIME_WIDTH-1:0]    rsp_start_ff;
   logic [soq_pkg::TIME_WIDTH-1:0]    rsp_stop_ff;

   logic                              out_free;
   logic                              fire;
   logic                              expired;
   logic [soq_pkg::TIME_WIDTH-1:0]    ref_time;
   logic [soq_pkg::TIME_WIDTH-1:0]    elapsed;

   assign csr_ready = 1'b1;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_free;
   assign fire      = in_valid_ff && out_free;

   // confirm seat measures from started_at, confirm leave from stopped_at
   assign ref_time = (phase_ff == PH_CONFIRM_SEAT) ? started_ff : stopped_ff;
   assign elapsed  = in_time_ff - ref_time;
   // time going backwards never expires
   assign expired  = (in_time_ff >= ref_time) &&
                     (soq_pkg::CMP_WIDTH'(elapsed) > soq_pkg::CMP_WIDTH'(timeout_ff));

   always_comb begin
      phase_in   = phase_ff;
      started_in = started_ff;
      stopped_in = stopped_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (in_occ_ff) begin
               phase_in   = PH_CONFIRM_SEAT;
               started_in = in_time_ff;
               stopped_in = in_time_ff;
            end else begin
               started_in = '0;
               stopped_in = '0;
            end
         end
         PH_CONFIRM_SEAT: begin
            if (!in_occ_ff) begin
               phase_in   = PH_IDLE;
               started_in = '0;
            end else if (expired) begin
               phase_in   = PH_STARTED;
               started_in = in_time_ff;
            end
            stopped_in = in_time_ff;
         end
         PH_STARTED: begin
            phase_in = PH_SEATED;
         end
         PH_SEATED: begin
            if (!in_occ_ff) begin
               phase_in = PH_CONFIRM_LEAVE;
            end
            stopped_in = in_time_ff;
         end
         PH_CONFIRM_LEAVE: begin
            if (in_occ_ff) begin
               phase_in   = PH_SEATED;
               stopped_in = '0;
            end else if (expired) begin
               phase_in = PH_STOPPED;
            end
         end
         PH_STOPPED: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= '0;
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_IDLE;
         started_ff   <= '0;
         stopped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_confirm_timeout;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            phase_ff   <= phase_in;
            started_ff <= started_in;
            stopped_ff <= stopped_in;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_occ_ff  <= req_seat_occupied;
         in_time_ff <= req_timestamp;
      end
      if (fire) begin
         rsp_phase_ff <= phase_in;
         rsp_start_ff <= started_in;
         rsp_stop_ff  <= stopped_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phase_code  = rsp_phase_ff;
   assign rsp_start_stamp = rsp_start_ff;
   assign rsp_stop_stamp  = rsp_stop_ff;

endmodule

`default_nettype wire

// File: sv/soq_checker.sv
// ----------------------------------------------------------------------------
// seat occupancy qualifier checker
// port-level checks on reset, stall hold and result ordering of the phase machine
// ----------------------------------------------------------------------------
`default_nettype none

module soq_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [soq_pkg::PHASE_WIDTH-1:0]     rsp_phase_code,
   input wire logic [soq_pkg::TIME_WIDTH-1:0]      rsp_start_stamp,
   input wire logic [soq_pkg::TIME_WIDTH-1:0]      rsp_stop_stamp
);

   logic                            rsp_beat;
   logic                            seen_ff;
   logic [soq_pkg::PHASE_WIDTH-1:0] last_phase_ff;

   assign rsp_beat = rsp_valid && !rsp_stall;

   // phase of the previous result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= 1'b0;
         last_phase_ff <= soq_pkg::PHASE_IDLE;
      end else if (rsp_beat) begin
         seen_ff       <= 1'b1;
         last_phase_ff <= rsp_phase_code;
      end
   end

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_phase_code) &&
      $stable(rsp_start_stamp) && $stable(rsp_stop_stamp))
      else $error("stalled result changed");

   a_started_then_seated: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && seen_ff && last_phase_ff == soq_pkg::PHASE_STARTED |->
      rsp_phase_code == soq_pkg::PHASE_SEATED)
      else $error("started pulse not followed by seated");

   a_stopped_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && seen_ff && last_phase_ff == soq_pkg::PHASE_STOPPED |->
      rsp_phase_code == soq_pkg::PHASE_IDLE)
      else $error("stopped pulse not followed by idle");

   a_confirm_seat_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && seen_ff && rsp_phase_code == soq_pkg::PHASE_CONFIRM_SEAT |->
      last_phase_ff == soq_pkg::PHASE_IDLE ||
      last_phase_ff == soq_pkg::PHASE_CONFIRM_SEAT)
      else $error("confirm seat entered from wrong phase");

endmodule

bind seat_occupancy_qualifier_unit soq_checker u_soq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_phase_code  (rsp_phase_code),
   .rsp_start_stamp (rsp_start_stamp),
   .rsp_stop_stamp  (rsp_stop_stamp)
);

`default_nettype wire

// File: dv/seat_occupancy_qualifier_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seat occupancy qualifier unit test
// drives timestamped seat samples through the qualifier under several confirm
// timeouts, predicts each phase/stamp result in a scoreboard and checks every
// result beat in order, with random idling and stalls on both channels
// ----------------------------------------------------------------------------

module seat_occupancy_qualifier_unit_test;

   typedef logic [soq_pkg::TIME_WIDTH-1:0]    stamp_type;
   typedef logic [soq_pkg::TIMEOUT_WIDTH-1:0] timeout_type;
   typedef logic [soq_pkg::PHASE_WIDTH-1:0]   phase_code_type;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam stamp_type   STAMP_MAX   = '1;
   localparam timeout_type TIMEOUT_MAX = '1;

   typedef struct packed {
      phase_code_type phase_code;
      stamp_type      start_stamp;
      stamp_type      stop_stamp;
   } qual_result_type;

   // tracks the qualifier state and the results still owed on rsp_
   class occupancy_board;
      timeout_type       timeout;
      phase_code_type    phase;
      stamp_type         started_at;
      stamp_type         stopped_at;
      qual_result_type   expected_q[$];
      int unsigned       fail_count;

      function new();
         timeout    = '0;
         phase      = soq_pkg::PHASE_IDLE;
         started_at = '0;
         stopped_at = '0;
         fail_count = 0;
      endfunction

      function void set_timeout(timeout_type value);
         timeout = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // a stamp below its base never counts as lapsed
      function bit has_lapsed(stamp_type now_ts, stamp_type base_ts);
         if (now_ts < base_ts)
            return 1'b0;
         return (now_ts - base_ts) > timeout;
      endfunction

      function void note_sample(bit occ, stamp_type ts);
         qual_result_type r;
         case (phase)
            soq_pkg::PHASE_IDLE: begin
               if (occ) begin
                  phase      = soq_pkg::PHASE_CONFIRM_SEAT;
                  started_at = ts;
                  stopped_at = ts;
               end else begin
                  started_at = '0;
                  stopped_at = '0;
               end
            end
            soq_pkg::PHASE_CONFIRM_SEAT: begin
               if (!occ) begin
                  phase      = soq_pkg::PHASE_IDLE;
                  started_at = '0;
               end else if (has_lapsed(ts, started_at)) begin
                  started_at = ts;
                  phase      = soq_pkg::PHASE_STARTED;
               end
               stopped_at = ts;
            end
            soq_pkg::PHASE_STARTED: begin
               phase = soq_pkg::PHASE_SEATED;
            end
            soq_pkg::PHASE_SEATED: begin
               if (!occ)
                  phase = soq_pkg::PHASE_CONFIRM_LEAVE;
               stopped_at = ts;
            end
            soq_pkg::PHASE_CONFIRM_LEAVE: begin
               if (occ) begin
                  phase      = soq_pkg::PHASE_SEATED;
                  stopped_at = '0;
               end else if (has_lapsed(ts, stopped_at)) begin
                  phase = soq_pkg::PHASE_STOPPED;
               end
            end
            default: begin
               // stopped, and any unused code, falls back to idle
               phase = soq_pkg::PHASE_IDLE;
            end
         endcase
         r.phase_code  = phase;
         r.start_stamp = started_at;
         r.stop_stamp  = stopped_at;
         expected_q.push_back(r);
      endfunction

      task flag_mismatch(string msg);
         if (fail_count < 40)
            $display("%0t: %s", $time, msg);
         fail_count++;
      endtask

      task check_result(phase_code_type ph, stamp_type st, stamp_type sp);
         qual_result_type want;
         if (expected_q.size() == 0) begin
            flag_mismatch("result beat with nothing outstanding");
            return;
         end
         want = expected_q.pop_front();
         if (ph !== want.phase_code)
            flag_mismatch($sformatf("phase_code got %0d want %0d", ph, want.phase_code));
         if (st !== want.start_stamp)
            flag_mismatch($sformatf("start_stamp got %0d want %0d", st, want.start_stamp));
         if (sp !== want.stop_stamp)
            flag_mismatch($sformatf("stop_stamp got %0d want %0d", sp, want.stop_stamp));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_seat_occupied = 1'b0;
   stamp_type                req_timestamp = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   phase_code_type           rsp_phase_code;
   stamp_type                rsp_start_stamp;
   stamp_type                rsp_stop_stamp;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   timeout_type              csr_confirm_timeout = '0;

   occupancy_board           board = new();
   bit                       gaps_on = 1'b1;
   bit                       stalls_on = 1'b1;
   stamp_type                stamp_now = '0;
   int unsigned              quiet_cycles = 0;

   seat_occupancy_qualifier_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_seat_occupied   (req_seat_occupied),
      .req_timestamp       (req_timestamp),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_phase_code      (rsp_phase_code),
      .rsp_start_stamp     (rsp_start_stamp),
      .rsp_stop_stamp      (rsp_stop_stamp),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_confirm_timeout (csr_confirm_timeout)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check every beat, stall now and then
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_phase_code, rsp_start_stamp, rsp_stop_stamp);
      rsp_stall <= stalls_on && ($urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a clock edge; returns at the edge where the beat was taken, or after a random idle gap
   task send_sample(bit occ, stamp_type ts);
      req_valid         <= 1'b1;
      req_seat_occupied <= occ;
      req_timestamp     <= ts;
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.note_sample(occ, ts);
      if (gaps_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task write_timeout(timeout_type value);
      csr_valid           <= 1'b1;
      csr_confirm_timeout <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      board.set_timeout(value);
      csr_valid <= 1'b0;
   endtask

   // mostly sit-down / stand-up sessions with jittered steps, some glitches,
   // and the odd sample at a random stamp (backwards jumps included)
   task drive_sessions(int unsigned n_samples, timeout_type tmo);
      int unsigned sent;
      int unsigned step_max;
      int unsigned run_len;
      bit          level;
      bit          occ;
      sent     = 0;
      step_max = 32'(tmo >> 1) + 2;
      while (sent < n_samples) begin
         if ($urandom_range(99) < 15) begin
            stamp_now = stamp_type'($urandom);
            send_sample(1'($urandom_range(0, 1)), stamp_now);
            sent++;
         end else begin
            level = 1'b1;
            repeat (2) begin
               run_len = $urandom_range(1, 8);
               repeat (run_len) begin
                  occ       = level ^ ($urandom_range(99) < 8);
                  stamp_now = stamp_now + stamp_type'($urandom_range(0, step_max));
                  send_sample(occ, stamp_now);
                  sent++;
               end
               level = 1'b0;
            end
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed walk through every phase with a timeout of three
      write_timeout(timeout_type'(3));
      send_sample(1'b0, stamp_type'(0));
      send_sample(1'b1, stamp_type'(10));
      send_sample(1'b1, stamp_type'(12));
      send_sample(1'b1, stamp_type'(13));   // elapsed equals timeout, not yet
      send_sample(1'b1, stamp_type'(14));   // started
      send_sample(1'b1, stamp_type'(15));   // seated
      send_sample(1'b1, stamp_type'(16));
      send_sample(1'b0, stamp_type'(17));   // confirm leave
      send_sample(1'b0, stamp_type'(20));
      send_sample(1'b1, stamp_type'(21));   // back to seated, stop stamp cleared
      send_sample(1'b0, stamp_type'(22));
      send_sample(1'b0, stamp_type'(10));   // stamp going backwards never lapses
      send_sample(1'b0, stamp_type'(26));   // stopped
      send_sample(1'b0, stamp_type'(27));   // idle
      send_sample(1'b1, stamp_type'(30));
      send_sample(1'b0, stamp_type'(31));   // seat abandoned while confirming
      send_sample(1'b1, STAMP_MAX);
      send_sample(1'b1, stamp_type'(0));    // backwards while confirming seat
      send_sample(1'b1, STAMP_MAX);
      send_sample(1'b1, STAMP_MAX);
      drain_results();

      // long stretch with no idling on either side
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      write_timeout(timeout_type'(0));
      drive_sessions(300, timeout_type'(0));
      gaps_on   = 1'b1;
      stalls_on = 1'b1;

      write_timeout(timeout_type'(1));
      drive_sessions(300, timeout_type'(1));
      begin
         timeout_type tmo;
         tmo = timeout_type'($urandom_range(2, 60));
         write_timeout(tmo);
         drive_sessions(300, tmo);
         write_timeout(TIMEOUT_MAX);
         drive_sessions(300, TIMEOUT_MAX);
         tmo = timeout_type'($urandom);
         write_timeout(tmo);
         drive_sessions(300, tmo);
         tmo = timeout_type'($urandom_range(5, 20));
         write_timeout(tmo);
         drive_sessions(300, tmo);
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (board.fail_count == 0 && board.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
